>>> design/ubxr_pkg.sv
// ubxr_pkg: shared constants and types for the ubx frame receiver
// no dependencies; used by the parser and the top level

package ubxr_pkg;

    // sync pattern that opens every frame
    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    // configuration register defaults and map
    localparam int unsigned   PADDR_W          = 3;
    localparam logic [15:0]   MAX_LEN_RST      = 16'd1024;
    localparam logic          REG_IDX_MAX_LEN  = 1'b0;

    // frame report codes
    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_BAD_CK   = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    // parser phase, one-hot
    typedef enum logic [7:0] {
        PH_HUNT    = 8'b0000_0001,
        PH_SYNC2   = 8'b0000_0010,
        PH_CLASS   = 8'b0000_0100,
        PH_ID      = 8'b0000_1000,
        PH_LEN_LO  = 8'b0001_0000,
        PH_LEN_HI  = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_CK      = 8'b1000_0000
    } t_phase;

    // one frame report
    typedef struct packed {
        t_status     status;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_len;
    } t_result;

endpackage

>>> design/ubxr_if.sv
// ubxr_if: valid/ready channels for the receiver byte stream and the frame reports
// depends on nothing; payload widths follow the field definitions

interface ubxr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxr_frame_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_status;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_len;

    modport source (output valid, output frame_status, output msg_class,
                    output msg_id, output payload_len, input ready);
    modport sink   (input valid, input frame_status, input msg_class,
                    input msg_id, input payload_len, output ready);
endinterface

>>> design/ubxr_parser.sv
// ubxr_parser: frame state machine, fletcher sums and length check
// depends on ubxr_pkg; one byte per cycle, report comes out combinationally

module ubxr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_byte_vld,
    input  logic [7:0]           i_byte,
    input  logic [15:0]          i_max_len,
    output logic                 o_res_vld,
    output ubxr_pkg::t_result    o_res
);

    ubxr_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_class, n_class;
    logic [7:0]  r_id, n_id;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_sum_a, n_sum_a;
    logic [7:0]  r_sum_b, n_sum_b;
    logic [7:0]  r_ck_a, n_ck_a;

    // fletcher step on the running sums
    logic [7:0]  w_add_a;
    logic [7:0]  w_add_b;
    logic [15:0] w_full_len;
    logic [15:0] w_cnt_inc;

    assign w_add_a    = r_sum_a + i_byte;
    assign w_add_b    = r_sum_b + w_add_a;
    assign w_full_len = {i_byte, r_len[7:0]};
    assign w_cnt_inc  = r_cnt + 16'd1;

    // next state for one byte
    always_comb begin
        n_phase   = r_phase;
        n_class   = r_class;
        n_id      = r_id;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_sum_a   = r_sum_a;
        n_sum_b   = r_sum_b;
        n_ck_a    = r_ck_a;
        o_res_vld = 1'b0;
        o_res     = '{status: ubxr_pkg::ST_GOOD, msg_class: r_class,
                      msg_id: r_id, payload_len: r_len};
        if (i_byte_vld) begin
            unique case (r_phase)
                ubxr_pkg::PH_HUNT: begin
                    if (i_byte == ubxr_pkg::SYNC_FIRST) begin
                        n_phase = ubxr_pkg::PH_SYNC2;
                    end
                end
                ubxr_pkg::PH_SYNC2: begin
                    // repeated first sync byte keeps waiting
                    if (i_byte == ubxr_pkg::SYNC_SECOND) begin
                        n_phase = ubxr_pkg::PH_CLASS;
                    end else if (i_byte != ubxr_pkg::SYNC_FIRST) begin
                        n_phase = ubxr_pkg::PH_HUNT;
                    end
                end
                ubxr_pkg::PH_CLASS: begin
                    n_class = i_byte;
                    n_sum_a = i_byte;
                    n_sum_b = i_byte;
                    n_phase = ubxr_pkg::PH_ID;
                end
                ubxr_pkg::PH_ID: begin
                    n_id    = i_byte;
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_phase = ubxr_pkg::PH_LEN_LO;
                end
                ubxr_pkg::PH_LEN_LO: begin
                    n_len   = {8'd0, i_byte};
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_phase = ubxr_pkg::PH_LEN_HI;
                end
                ubxr_pkg::PH_LEN_HI: begin
                    n_len   = w_full_len;
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_cnt   = '0;
                    if (w_full_len > i_max_len) begin
                        // oversize frame is reported and dropped here
                        n_phase           = ubxr_pkg::PH_HUNT;
                        o_res_vld         = 1'b1;
                        o_res.status      = ubxr_pkg::ST_TOO_LONG;
                        o_res.payload_len = w_full_len;
                    end else if (w_full_len == 16'd0) begin
                        n_phase = ubxr_pkg::PH_CK;
                        n_cnt   = 16'd1;
                    end else begin
                        n_phase = ubxr_pkg::PH_PAYLOAD;
                    end
                end
                ubxr_pkg::PH_PAYLOAD: begin
                    n_sum_a = w_add_a;
                    n_sum_b = w_add_b;
                    n_cnt   = w_cnt_inc;
                    if (w_cnt_inc >= r_len) begin
                        n_phase = ubxr_pkg::PH_CK;
                        n_cnt   = 16'd1;
                    end
                end
                ubxr_pkg::PH_CK: begin
                    // count 1 marks the first checksum byte, 0 the second
                    if (r_cnt[0]) begin
                        n_ck_a = i_byte;
                        n_cnt  = '0;
                    end else begin
                        n_phase   = ubxr_pkg::PH_HUNT;
                        o_res_vld = 1'b1;
                        if (r_sum_a == r_ck_a && r_sum_b == i_byte) begin
                            o_res.status = ubxr_pkg::ST_GOOD;
                        end else begin
                            o_res.status = ubxr_pkg::ST_BAD_CK;
                        end
                    end
                end
                default: begin
                    n_phase = ubxr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ubxr_pkg::PH_HUNT;
        end else begin
            r_phase <= n_phase;
        end
    end

    // frame fields and sums
    always_ff @(posedge i_clk) begin
        r_class <= n_class;
        r_id    <= n_id;
        r_len   <= n_len;
        r_cnt   <= n_cnt;
        r_sum_a <= n_sum_a;
        r_sum_b <= n_sum_b;
        r_ck_a  <= n_ck_a;
    end

endmodule

>>> design/ubx_frame_receiver.sv
// ubx_frame_receiver: ubx frame parser with fletcher-8 check and apb limit register
// depends on ubxr_pkg, ubxr_if and ubxr_parser
//
//  channel   dir  handshake      payload
//  i_rx      in   valid/ready    rx_byte[7:0]
//  o_frame   out  valid/ready    frame_status[1:0] msg_class msg_id payload_len[15:0]
//  apb       in   psel/penable   max_payload_len at byte address 0
//
// one byte per cycle while i_rx.ready is high; the report for the byte that closes
// the frame (second checksum byte, or high length byte of an oversize frame) is
// registered into the output register, or into the one-entry skid stage while a
// report waits, so input keeps flowing; i_rx.ready drops only when both are full.
// synchronous active-low reset returns to sync hunting with the limit at 1024.

module ubx_frame_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ubxr_byte_if.sink                     i_rx,
    ubxr_frame_if.source                  o_frame,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ubxr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [15:0]       r_max_len;
    logic              w_accept;
    logic              w_res_vld;
    ubxr_pkg::t_result w_res;
    logic              w_push;
    logic              w_pop;
    logic              r_out_vld, n_out_vld;
    ubxr_pkg::t_result r_out, n_out;
    logic              r_skd_vld, n_skd_vld;
    ubxr_pkg::t_result r_skd, n_skd;

    // apb register access
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ubxr_pkg::MAX_LEN_RST;
        end else if (psel && penable && pwrite &&
                     paddr[2] == ubxr_pkg::REG_IDX_MAX_LEN) begin
            r_max_len <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ubxr_pkg::REG_IDX_MAX_LEN) begin
            prdata = {16'd0, r_max_len};
        end
    end

    // byte transaction
    assign i_rx.ready = !r_skd_vld;
    assign w_accept   = i_rx.valid && !r_skd_vld;

    ubxr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte_vld (w_accept),
        .i_byte     (i_rx.rx_byte),
        .i_max_len  (r_max_len),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res)
    );

    // output register with skid stage
    assign w_push = w_accept && w_res_vld;
    assign w_pop  = r_out_vld && o_frame.ready;

    always_comb begin
        n_out_vld = r_out_vld;
        n_out     = r_out;
        n_skd_vld = r_skd_vld;
        n_skd     = r_skd;
        if (r_out_vld && !w_pop) begin
            if (w_push) begin
                n_skd_vld = 1'b1;
                n_skd     = w_res;
            end
        end else if (r_skd_vld) begin
            n_out_vld = 1'b1;
            n_out     = r_skd;
            n_skd_vld = 1'b0;
        end else begin
            n_out_vld = w_push;
            n_out     = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
            r_skd_vld <= n_skd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skd <= n_skd;
    end

    // frame report transaction
    assign o_frame.valid        = r_out_vld;
    assign o_frame.frame_status = r_out.status;
    assign o_frame.msg_class    = r_out.msg_class;
    assign o_frame.msg_id       = r_out.msg_id;
    assign o_frame.payload_len  = r_out.payload_len;

endmodule
